// ===== rtl/tle_pkg.sv =====
// Shared types and byte codes for the telnet line editor.
`timescale 1ns / 1ps

package tle_pkg;

    localparam int LINE_MAX_DEF = 256;

    localparam logic [7:0] BYTE_IAC   = 8'd255;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_TILDE = 8'd126;
    localparam logic [7:0] CMD_WILL   = 8'd251;
    localparam logic [7:0] CMD_DO     = 8'd253;
    localparam logic [7:0] CMD_DONT   = 8'd254;
    localparam logic [7:0] OPT_ECHO   = 8'd1;

    localparam logic [1:0] ECNT_NONE  = 2'd0;
    localparam logic [1:0] ECNT_CHAR  = 2'd1;
    localparam logic [1:0] ECNT_CRLF  = 2'd2;
    localparam logic [1:0] ECNT_ERASE = 2'd3;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_CMD  = 2'd1,
        PH_OPT  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_DONE   = 2'd3
    } t_action;

    // Parser control state, apart from the line counter.
    typedef struct packed {
        t_phase phase;
        logic   pend_do;
        logic   pend_dont;
        logic   echo_on;
    } t_parse;

    typedef struct packed {
        logic [1:0] echo_count;
        logic [7:0] echo_first;
        logic [7:0] echo_second;
        logic [7:0] echo_third;
        t_action    line_action;
        logic [7:0] line_char;
        logic [8:0] line_length;
        logic       char_dropped;
    } t_result;

endpackage

// ===== rtl/tle_ifs.sv =====
// Handshake interfaces for the received byte channel and the result channel.
`timescale 1ns / 1ps

interface tle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tle_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] echo_count;
    logic [7:0] echo_first;
    logic [7:0] echo_second;
    logic [7:0] echo_third;
    logic [1:0] line_action;
    logic [7:0] line_char;
    logic [8:0] line_length;
    logic       char_dropped;

    modport source (output valid, output echo_count, output echo_first, output echo_second,
                    output echo_third, output line_action, output line_char,
                    output line_length, output char_dropped, input ready);
    modport sink (input valid, input echo_count, input echo_first, input echo_second,
                  input echo_third, input line_action, input line_char,
                  input line_length, input char_dropped, output ready);
endinterface

// ===== rtl/tle_step.sv =====
// Combinational parse step: one byte against the current state.
`timescale 1ns / 1ps

module tle_step
    import tle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF,
    localparam int CNT_W   = $clog2(LINE_MAX + 1)
) (
    input  t_parse           i_parse,
    input  logic [CNT_W-1:0] i_count,
    input  logic [7:0]       i_byte,
    output t_parse           o_parse,
    output logic [CNT_W-1:0] o_count,
    output t_result          o_res
);

    t_result w_res;

    always_comb begin
        o_parse = i_parse;
        o_count = i_count;
        w_res   = '0;

        case (i_parse.phase)
            PH_CMD: begin
                if (i_byte inside {[CMD_WILL:CMD_DONT]}) begin
                    o_parse.pend_do   = (i_byte == CMD_DO);
                    o_parse.pend_dont = (i_byte == CMD_DONT);
                    o_parse.phase     = PH_OPT;
                end else begin
                    o_parse.phase = PH_TEXT;
                end
            end
            PH_OPT: begin
                if (i_byte == OPT_ECHO) begin
                    if (i_parse.pend_do) begin
                        o_parse.echo_on = 1'b1;
                    end else if (i_parse.pend_dont) begin
                        o_parse.echo_on = 1'b0;
                    end
                end
                o_parse.pend_do   = 1'b0;
                o_parse.pend_dont = 1'b0;
                o_parse.phase     = PH_TEXT;
            end
            PH_TEXT: begin
                if (i_byte == BYTE_IAC) begin
                    o_parse.phase = PH_CMD;
                end else if (i_byte == BYTE_CR) begin
                    w_res.line_action = ACT_DONE;
                    w_res.line_length = 9'(i_count);
                    w_res.echo_count  = ECNT_CRLF;
                    w_res.echo_first  = BYTE_CR;
                    w_res.echo_second = BYTE_LF;
                    o_count           = '0;
                end else if (i_byte inside {BYTE_BS, BYTE_DEL}) begin
                    if (i_count != '0) begin
                        o_count           = i_count - CNT_W'(1);
                        w_res.line_action = ACT_DELETE;
                        w_res.echo_count  = ECNT_ERASE;
                        w_res.echo_first  = i_byte;
                        w_res.echo_second = BYTE_SPACE;
                        w_res.echo_third  = i_byte;
                    end
                end else if (i_byte inside {[BYTE_SPACE:BYTE_TILDE]}) begin
                    if (i_count < CNT_W'(LINE_MAX)) begin
                        o_count           = i_count + CNT_W'(1);
                        w_res.line_action = ACT_APPEND;
                        w_res.line_char   = i_byte;
                        w_res.echo_count  = ECNT_CHAR;
                        w_res.echo_first  = i_byte;
                    end else begin
                        w_res.char_dropped = 1'b1;
                    end
                end
            end
            default: begin
                o_parse.phase = PH_TEXT;
            end
        endcase

        o_res = w_res;
        // Mask the echo bytes while echo is off.
        if (!o_parse.echo_on) begin
            o_res.echo_count  = ECNT_NONE;
            o_res.echo_first  = '0;
            o_res.echo_second = '0;
            o_res.echo_third  = '0;
        end
    end

endmodule

// ===== rtl/telnet_line_editor.sv =====
// Top level of the telnet line editor: input register, parse step, result register.
`timescale 1ns / 1ps
// An accepted item passes the input register, then the result register, before it shows on o_res.
// Throughput: one item per cycle while o_res.ready stays high; the combinational parse step
//   between the input and result registers updates parse state and the line counter together.
// Reset (i_rst_n low, synchronous): both register stages empty, text phase, echo off,
//   empty line.

module telnet_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tle_rx_if.sink     i_rx,
    tle_res_if.source  o_res
);

    localparam int CNT_W = $clog2(LINE_MAX + 1);

    // Input stage: hold one received byte until the step can take it.
    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    // Parse state and line counter.
    t_parse           r_parse;
    t_parse           n_parse;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result stage.
    logic             r_out_valid;
    t_result          r_res;
    t_result          n_res;

    logic             w_adv;
    logic             w_in_take;

    // Advance the held byte whenever the result register is empty or being drained.
    assign w_adv     = r_in_valid && (!r_out_valid || o_res.ready);
    // Take a new byte when the input register is empty or moves on this cycle.
    assign i_rx.ready = !r_in_valid || w_adv;
    assign w_in_take = i_rx.valid && i_rx.ready;

    tle_step #(
        .LINE_MAX (LINE_MAX)
    ) u_step (
        .i_parse (r_parse),
        .i_count (r_count),
        .i_byte  (r_in_byte),
        .o_parse (n_parse),
        .o_count (n_count),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Commit state only when the byte actually moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse <= '{phase: PH_TEXT, pend_do: 1'b0, pend_dont: 1'b0, echo_on: 1'b0};
            r_count <= '0;
        end else if (w_adv) begin
            r_parse <= n_parse;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.echo_count   = r_res.echo_count;
    assign o_res.echo_first   = r_res.echo_first;
    assign o_res.echo_second  = r_res.echo_second;
    assign o_res.echo_third   = r_res.echo_third;
    assign o_res.line_action  = r_res.line_action;
    assign o_res.line_char    = r_res.line_char;
    assign o_res.line_length  = r_res.line_length;
    assign o_res.char_dropped = r_res.char_dropped;

    // The line counter never passes the line limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LINE_MAX))
        else $error("line counter beyond limit");

    // An append result goes with the counter one higher than before.
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_res.line_action == ACT_APPEND) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not advance line counter");

    // A completed line clears the counter.
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_res.line_action == ACT_DONE) |=> (r_count == '0))
        else $error("line complete left characters in counter");

    // A dropped character leaves the line untouched.
    a_drop_no_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.char_dropped) |-> (r_res.line_action == ACT_NONE))
        else $error("dropped character with line action");

    // No echo leaves the block while echo is off.
    a_echo_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !n_parse.echo_on) |=> (r_res.echo_count == ECNT_NONE))
        else $error("echo produced while echo off");

endmodule

// ===== tb/telnet_line_editor_tb.sv =====
// Self-checking testbench for the telnet line editor: byte stimulus, result prediction, checks.
`timescale 1ns / 1ps

module telnet_line_editor_tb;
    import tle_pkg::*;

    // Tracks the parser, echo flag and line length of the editor and holds the
    // results that are still owed, oldest first.
    class echo_line_tracker;
        t_phase      phase;
        bit          pend_do;
        bit          pend_dont;
        bit          echo_on;
        int unsigned line_len;
        int unsigned line_cap;
        t_result     owed_q[$];
        int unsigned failures;
        int unsigned bad_results;

        function new(int unsigned cap);
            line_cap    = cap;
            phase       = PH_TEXT;
            pend_do     = 1'b0;
            pend_dont   = 1'b0;
            echo_on     = 1'b0;
            line_len    = 0;
            failures    = 0;
            bad_results = 0;
        endfunction

        function int unsigned owed();
            return owed_q.size();
        endfunction

        // Advance the editor state by one received byte and queue the result it causes.
        function void take_byte(logic [7:0] b);
            t_result r;
            r = '0;
            r.line_action = ACT_NONE;
            case (phase)
                PH_CMD: begin
                    if (b >= CMD_WILL && b <= CMD_DONT) begin
                        pend_do   = (b == CMD_DO);
                        pend_dont = (b == CMD_DONT);
                        phase     = PH_OPT;
                    end else begin
                        phase = PH_TEXT;
                    end
                end
                PH_OPT: begin
                    if (b == OPT_ECHO) begin
                        if (pend_do)
                            echo_on = 1'b1;
                        else if (pend_dont)
                            echo_on = 1'b0;
                    end
                    pend_do   = 1'b0;
                    pend_dont = 1'b0;
                    phase     = PH_TEXT;
                end
                default: begin
                    phase = PH_TEXT;
                    if (b == BYTE_IAC) begin
                        phase = PH_CMD;
                    end else if (b == BYTE_CR) begin
                        r.line_action = ACT_DONE;
                        r.line_length = 9'(line_len);
                        line_len      = 0;
                        r.echo_count  = ECNT_CRLF;
                        r.echo_first  = BYTE_CR;
                        r.echo_second = BYTE_LF;
                    end else if (b == BYTE_BS || b == BYTE_DEL) begin
                        if (line_len > 0) begin
                            line_len      = line_len - 1;
                            r.line_action = ACT_DELETE;
                            r.echo_count  = ECNT_ERASE;
                            r.echo_first  = b;
                            r.echo_second = BYTE_SPACE;
                            r.echo_third  = b;
                        end
                    end else if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
                        if (line_len < line_cap) begin
                            line_len      = line_len + 1;
                            r.line_action = ACT_APPEND;
                            r.line_char   = b;
                            r.echo_count  = ECNT_CHAR;
                            r.echo_first  = b;
                        end else begin
                            r.char_dropped = 1'b1;
                        end
                    end
                end
            endcase
            if (!echo_on) begin
                r.echo_count  = ECNT_NONE;
                r.echo_first  = '0;
                r.echo_second = '0;
                r.echo_third  = '0;
            end
            owed_q.push_back(r);
        endfunction

        function string show(t_result r);
            return $sformatf("cnt=%0d e=%0d/%0d/%0d act=%0d chr=%0d len=%0d drop=%0d",
                             r.echo_count, r.echo_first, r.echo_second, r.echo_third,
                             r.line_action, r.line_char, r.line_length, r.char_dropped);
        endfunction

        // Compare one delivered result with the oldest owed one.
        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (owed_q.size() == 0) begin
                failures++;
                bad_results++;
                if (bad_results <= 10)
                    $display("ERROR: unexpected result %s", show(got));
                return;
            end
            want = owed_q.pop_front();
            bad = (got.echo_count   !== want.echo_count)  ||
                  (got.echo_first   !== want.echo_first)  ||
                  (got.echo_second  !== want.echo_second) ||
                  (got.echo_third   !== want.echo_third)  ||
                  (got.line_action  !== want.line_action) ||
                  (got.line_char    !== want.line_char)   ||
                  (got.line_length  !== want.line_length) ||
                  (got.char_dropped !== want.char_dropped);
            if (bad) begin
                failures++;
                bad_results++;
                if (bad_results <= 10)
                    $display("ERROR: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    localparam int unsigned ITEM_TARGET = 1250;  // stop offering random bytes here
    localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int unsigned IDLE_LIMIT  = 4000;  // watchdog: cycles with no handshake

    logic clk;
    logic rst_n;

    tle_rx_if  rx_if ();
    tle_res_if res_if ();

    telnet_line_editor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    echo_line_tracker tracker = new(LINE_MAX_DEF);

    int unsigned bytes_sent;
    int unsigned idle_cycles;
    bit          tx_calm;   // sender offers back to back while set
    bit          hold_req;  // asks the receiver for one long hold-off

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Drive every input to a known value from time zero.
    initial begin
        rst_n          <= 1'b0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        res_if.ready   <= 1'b0;
    end

    // Gap before the next offer or ready: mostly none or short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte and hold it until the editor takes it. Valid stays high
    // across back-to-back items so it is never lowered and raised in one step.
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_iac(logic [7:0] cmd, logic [7:0] opt);
        send_byte(BYTE_IAC);
        send_byte(cmd);
        send_byte(opt);
    endtask

    // Send n random printable characters; those past the line capacity get dropped.
    task automatic fill_line(int unsigned n);
        repeat (n) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
    endtask

    // Hold off new bytes until every owed result has come back.
    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.owed() != 0) @(posedge clk);
    endtask

    // One random stretch of traffic. Most of it is well-formed text and
    // commands; the rest is stray bytes and broken command sequences.
    task automatic random_burst();
        int unsigned k;
        int unsigned n;
        k = $urandom_range(0, 99);
        tx_calm = ($urandom_range(0, 3) == 0);
        if (k < 30) begin
            // a word of printable text
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
        end else if (k < 40) begin
            // erase some characters, mixing both delete codes
            n = $urandom_range(1, 4);
            repeat (n) send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
        end else if (k < 50) begin
            send_byte(BYTE_CR);
        end else if (k < 60) begin
            // turn echo on or off at random
            send_iac($urandom_range(0, 1) ? CMD_DO : CMD_DONT, OPT_ECHO);
        end else if (k < 68) begin
            // any option command, echo option half the time
            send_iac(8'($urandom_range(CMD_WILL, CMD_DONT)),
                     $urandom_range(0, 1) ? OPT_ECHO : 8'($urandom_range(0, 255)));
        end else if (k < 76) begin
            // command that takes no option: IAC IAC, CR after IAC, anything below WILL
            send_byte(BYTE_IAC);
            n = $urandom_range(0, 9);
            if (n == 0)
                send_byte(BYTE_IAC);
            else if (n == 1)
                send_byte(BYTE_CR);
            else
                send_byte(8'($urandom_range(0, CMD_WILL - 1)));
        end else if (k < 80) begin
            // broken sequence: IAC, a random byte, then text
            send_byte(BYTE_IAC);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
        end else if (k < 90) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (k < 95) begin
            send_byte(8'($urandom_range(0, BYTE_SPACE - 1)));
        end else begin
            send_byte(8'($urandom_range(BYTE_DEL + 1, BYTE_IAC - 1)));
        end
    endtask

    // Receiver: random ready gaps, runs of steady ready, and one long hold-off
    // counted here so the editor backs up and stalls its input.
    initial begin : receiver
        int unsigned gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Note accepted bytes and check delivered results. Both sides are sampled
    // at the rising edge, before the nonblocking updates of that edge land.
    always @(posedge clk) begin : monitor
        t_result got;
        if (rst_n) begin
            if (rx_if.valid && rx_if.ready)
                tracker.take_byte(rx_if.rx_byte);
            if (res_if.valid && res_if.ready) begin
                got.echo_count   = res_if.echo_count;
                got.echo_first   = res_if.echo_first;
                got.echo_second  = res_if.echo_second;
                got.echo_third   = res_if.echo_third;
                got.line_action  = t_action'(res_if.line_action);
                got.line_char    = res_if.line_char;
                got.line_length  = res_if.line_length;
                got.char_dropped = res_if.char_dropped;
                tracker.check_result(got);
            end
        end
    end

    // Watchdog: end the run if no handshake happens on either side for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] opening_seq [$];
        bytes_sent  = 0;
        idle_cycles = 0;
        tx_calm     = 1'b0;
        hold_req    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: ignored byte, echo on, both ends of the printable
        // range, both delete codes down to a delete on an empty line, an empty
        // line, CR as a command byte, IAC IAC, high and low noise, WILL ECHO
        // consumed without effect, then echo off again.
        opening_seq = '{8'd0,
                        BYTE_IAC, CMD_DO, OPT_ECHO,
                        8'h41, BYTE_SPACE, BYTE_TILDE,
                        BYTE_BS, BYTE_DEL, BYTE_DEL, BYTE_BS,
                        BYTE_CR,
                        8'h7a, BYTE_IAC, BYTE_CR, BYTE_CR,
                        BYTE_IAC, BYTE_IAC,
                        8'd31, 8'd128,
                        BYTE_IAC, CMD_WILL, OPT_ECHO,
                        BYTE_IAC, CMD_DONT, OPT_ECHO};
        foreach (opening_seq[i])
            send_byte(opening_seq[i]);

        // Full line with echo off: overflow drops, then a line of full length.
        tx_calm = 1'b1;
        fill_line(LINE_MAX_DEF + 6);
        send_byte(BYTE_CR);
        tx_calm = 1'b0;

        // Full line again with echo on, trim it a little, then fill to the brim.
        send_iac(CMD_DO, OPT_ECHO);
        fill_line(LINE_MAX_DEF + 2);
        send_byte(BYTE_DEL);
        send_byte(BYTE_BS);
        fill_line(3);
        send_byte(BYTE_CR);

        // First pause: let every owed result arrive before the random part.
        drain();

        while (bytes_sent < ITEM_TARGET) begin
            random_burst();
            // keep offering while the receiver holds off for a long stretch
            if (bytes_sent > 700 && bytes_sent < 720)
                hold_req = 1'b1;
            if (bytes_sent > 950 && bytes_sent < 970) begin
                tx_calm = 1'b0;
                drain();
            end
        end

        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.owed() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.owed() != 0)
            tracker.failures += tracker.owed();
        if (tracker.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tle_pkg.sv
rtl/tle_ifs.sv
rtl/tle_step.sv
rtl/telnet_line_editor.sv
tb/telnet_line_editor_tb.sv
